// ===== rtl/rbxy_pkg.sv =====
package rbxy_pkg;

  localparam int LINE_LIMIT_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int IN_W    = 8;
  localparam int OFF_W   = 9;
  localparam int MAXD_W  = 4;
  localparam int OUT_W   = 19;
  localparam int IDX_W   = 1;

  localparam logic [OFF_W-1:0]  OFFSET_RST = OFF_W'(43);
  localparam logic [MAXD_W-1:0] MAXD_RST   = MAXD_W'(10);

  localparam logic [IDX_W-1:0] CFG_ANGLE_OFFSET = 1'b0;
  localparam logic [IDX_W-1:0] CFG_MAX_DISTANCE = 1'b1;

  localparam int INT_W       = 9;
  localparam int INT_CAP     = 511;
  localparam int FDIG_W      = 30;
  localparam int FPOS_W      = 4;
  localparam int FRAC_DIGITS = 9;

  localparam int ANG_BITS     = 24;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int CW           = 28;
  localparam int ZW           = 33;
  localparam int TW           = 35;
  localparam int MAG_W        = 27;
  localparam int GAIN_W       = 30;
  localparam int DSC_W        = 14;
  localparam logic [GAIN_W-1:0] CORDIC_GAIN = GAIN_W'(652032874);
  localparam logic [DSC_W-1:0]  DIST_SCALE  = DSC_W'(16000);

  localparam logic [3:0] PH_HASH = 4'd0;
  localparam logic [3:0] PH_NUM1 = 4'd1;
  localparam logic [3:0] PH_NUM2 = 4'd6;
  localparam logic [3:0] PH_DONE = 4'd11;

  localparam logic [3:0] R_WS   = 4'd0;
  localparam logic [3:0] R_SIGN = 4'd1;
  localparam logic [3:0] R_INT  = 4'd2;
  localparam logic [3:0] R_DOT  = 4'd3;
  localparam logic [3:0] R_FRAC = 4'd4;

  localparam logic [1:0] RES_TAKE = 2'd0;
  localparam logic [1:0] RES_END  = 2'd1;
  localparam logic [1:0] RES_MAL  = 2'd2;

  typedef struct packed {
    logic step;
    logic div_run;
    logic div_fin;
    logic mul1;
    logic mul2;
    logic rot;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic start_div;
    logic go_check;
    logic div_last;
    logic line_ok;
    logic rot_last;
  } sts_t;

  function automatic logic [FDIG_W-1:0] pow10(input logic [FPOS_W-1:0] p);
    logic [FDIG_W-1:0] r;
    unique case (p)
      4'd0:    r = FDIG_W'(1);
      4'd1:    r = FDIG_W'(10);
      4'd2:    r = FDIG_W'(100);
      4'd3:    r = FDIG_W'(1000);
      4'd4:    r = FDIG_W'(10000);
      4'd5:    r = FDIG_W'(100000);
      4'd6:    r = FDIG_W'(1000000);
      4'd7:    r = FDIG_W'(10000000);
      4'd8:    r = FDIG_W'(100000000);
      4'd9:    r = FDIG_W'(1000000000);
      default: r = FDIG_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic [29:0] atan_deg(input logic [STEP_W-1:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:    r = 30'd754974720;
      5'd1:    r = 30'd445687602;
      5'd2:    r = 30'd235489088;
      5'd3:    r = 30'd119537938;
      5'd4:    r = 30'd60000934;
      5'd5:    r = 30'd30029717;
      5'd6:    r = 30'd15018523;
      5'd7:    r = 30'd7509720;
      5'd8:    r = 30'd3754917;
      5'd9:    r = 30'd1877466;
      5'd10:   r = 30'd938734;
      5'd11:   r = 30'd469367;
      5'd12:   r = 30'd234684;
      5'd13:   r = 30'd117342;
      5'd14:   r = 30'd58671;
      5'd15:   r = 30'd29335;
      5'd16:   r = 30'd14668;
      5'd17:   r = 30'd7334;
      5'd18:   r = 30'd3667;
      5'd19:   r = 30'd1833;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rbxy_ctrl.sv =====
module rbxy_ctrl
  import rbxy_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_DFIN = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_ROT  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       chk_r, chk_nxt;
  logic       ovld_r, ovld_nxt;

  always_comb begin
    state_nxt = state_r;
    chk_nxt   = chk_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = 1'b1;
          chk_nxt  = sts.go_check;
          if (sts.start_div) begin
            state_nxt = S_DIV;
          end else if (sts.go_check) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = chk_r ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        state_nxt = sts.line_ok ? S_MUL1 : S_IDLE;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rot = 1'b1;
        if (sts.rot_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovld_r || !out_stall) begin
          cmd.fin   = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chk_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;

endmodule

// ===== rtl/rbxy_dp.sv =====
module rbxy_dp
  import rbxy_pkg::*;
#(
  parameter int LINE_LIMIT = LINE_LIMIT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [IN_W-1:0]          rx_byte,
  input  logic signed [OFF_W-1:0]  angle_offset,
  input  logic [MAXD_W-1:0]        max_dist,
  output logic signed [OUT_W-1:0]  x_pos,
  output logic signed [OUT_W-1:0]  y_pos
);

  localparam int LC_W = $clog2(LINE_LIMIT);
  localparam int VW   = INT_W + FRAC_BITS + 1;
  localparam int DC_W = $clog2(FRAC_BITS);
  localparam int P1_W = VW - 1 + DSC_W;
  localparam int PR_W = MAG_W + GAIN_W;
  localparam logic [VW-1:0] BEAR_MAX = VW'(180) << FRAC_BITS;
  localparam logic [TW-1:0] HALF     = TW'(180) << ANG_BITS;
  localparam logic [TW-1:0] QUART    = TW'(90) << ANG_BITS;

  logic [LC_W-1:0]        line_cnt_r;
  logic [3:0]             phase_r;
  logic                   bad_r;
  logic [1:0]             sign_r;
  logic [INT_W-1:0]       int_r;
  logic [FDIG_W-1:0]      frac_r;
  logic [FPOS_W-1:0]      fpos_r;
  logic signed [VW-1:0]   dist_r;
  logic signed [VW-1:0]   bear_r;
  logic [FDIG_W-1:0]      rem_r;
  logic [FDIG_W-1:0]      dvs_r;
  logic [FRAC_BITS-1:0]   quot_r;
  logic [INT_W-1:0]       dint_r;
  logic                   dneg_r;
  logic                   dtgt_r;
  logic [DC_W-1:0]        dcnt_r;
  logic [P1_W-1:0]        p1_r;
  logic signed [TW-1:0]   theta_r;
  logic signed [CW-1:0]   x_r;
  logic signed [CW-1:0]   y_r;
  logic signed [ZW-1:0]   z_r;
  logic                   neg_r;
  logic [STEP_W-1:0]      step_r;
  logic signed [OUT_W-1:0] xo_r;
  logic signed [OUT_W-1:0] yo_r;

  logic [LC_W-1:0]   cnt_nxt;
  logic [3:0]        phase_nxt;
  logic              bad_nxt;
  logic [1:0]        sign_nxt;
  logic [INT_W-1:0]  int_nxt;
  logic [FDIG_W-1:0] frac_nxt;
  logic [FPOS_W-1:0] fpos_nxt;
  logic              div_go;
  logic              div_tgt;
  logic              go_chk;

  logic              is_dig;
  logic              is_sp;
  logic [3:0]        dval;
  logic              in_n1;
  logic              in_n2;
  logic [3:0]        base;
  logic [3:0]        rel;
  logic [1:0]        res;
  logic [3:0]        nrel;
  logic              set_neg;
  logic              add_i;
  logic              add_f;
  logic [12:0]       iv;
  logic              ovf;
  logic              bear_pend;

  assign is_dig = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_sp  = (rx_byte == 8'h20) || ((rx_byte >= 8'h09) && (rx_byte <= 8'h0D));
  assign dval   = rx_byte[3:0];
  assign in_n1  = (phase_r >= PH_NUM1) && (phase_r < PH_NUM2);
  assign in_n2  = (phase_r >= PH_NUM2) && (phase_r < PH_DONE);
  assign base   = in_n2 ? PH_NUM2 : PH_NUM1;
  assign rel    = phase_r - base;
  assign iv     = 13'(int_r) * 13'd10 + 13'(dval);
  assign ovf    = (line_cnt_r >= LC_W'(LINE_LIMIT - 1));
  assign bear_pend = !bad_r && in_n2 && ((rel == R_INT) || (rel == R_FRAC));

  always_comb begin
    res     = RES_MAL;
    nrel    = rel;
    set_neg = 1'b0;
    add_i   = 1'b0;
    add_f   = 1'b0;
    unique case (rel)
      R_WS: begin
        if (is_sp) begin
          res = RES_TAKE;
        end else if ((rx_byte == 8'h2B) || (rx_byte == 8'h2D)) begin
          res     = RES_TAKE;
          set_neg = (rx_byte == 8'h2D);
          nrel    = R_SIGN;
        end else if (is_dig) begin
          res   = RES_TAKE;
          add_i = 1'b1;
          nrel  = R_INT;
        end else if (rx_byte == 8'h2E) begin
          res  = RES_TAKE;
          nrel = R_DOT;
        end
      end
      R_SIGN: begin
        if (is_dig) begin
          res   = RES_TAKE;
          add_i = 1'b1;
          nrel  = R_INT;
        end else if (rx_byte == 8'h2E) begin
          res  = RES_TAKE;
          nrel = R_DOT;
        end
      end
      R_INT: begin
        res = RES_END;
        if (is_dig) begin
          res   = RES_TAKE;
          add_i = 1'b1;
        end else if (rx_byte == 8'h2E) begin
          res  = RES_TAKE;
          nrel = R_FRAC;
        end
      end
      R_DOT: begin
        if (is_dig) begin
          res   = RES_TAKE;
          add_f = 1'b1;
          nrel  = R_FRAC;
        end
      end
      R_FRAC: begin
        res = RES_END;
        if (is_dig) begin
          res   = RES_TAKE;
          add_f = 1'b1;
        end
      end
      default: res = RES_MAL;
    endcase
  end

  always_comb begin
    cnt_nxt   = line_cnt_r + LC_W'(1);
    phase_nxt = phase_r;
    bad_nxt   = bad_r;
    sign_nxt  = sign_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    fpos_nxt  = fpos_r;
    div_go    = 1'b0;
    div_tgt   = 1'b0;
    go_chk    = 1'b0;
    if (ovf || (rx_byte == 8'h0A)) begin
      if (!ovf) begin
        go_chk  = !bad_r && ((phase_r == PH_DONE) || bear_pend);
        div_go  = bear_pend;
        div_tgt = 1'b1;
      end
      cnt_nxt   = '0;
      phase_nxt = PH_HASH;
      bad_nxt   = 1'b0;
      sign_nxt  = 2'b00;
      int_nxt   = '0;
      frac_nxt  = '0;
      fpos_nxt  = '0;
    end else if (!bad_r && (phase_r != PH_DONE)) begin
      if (phase_r == PH_HASH) begin
        if (rx_byte == 8'h23) begin
          phase_nxt = PH_NUM1;
          int_nxt   = '0;
          frac_nxt  = '0;
          fpos_nxt  = '0;
        end else begin
          bad_nxt = 1'b1;
        end
      end else if ((in_n1 || in_n2) && (res == RES_TAKE)) begin
        phase_nxt = base + nrel;
        if (set_neg) begin
          sign_nxt = sign_r | (in_n2 ? 2'b10 : 2'b01);
        end
        if (add_i) begin
          int_nxt = (iv > 13'(INT_CAP)) ? INT_W'(INT_CAP) : iv[INT_W-1:0];
        end
        if (add_f && (fpos_r < FPOS_W'(FRAC_DIGITS))) begin
          frac_nxt = frac_r * FDIG_W'(10) + FDIG_W'(dval);
          fpos_nxt = fpos_r + FPOS_W'(1);
        end
      end else if (in_n1) begin
        if ((res == RES_END) && (rx_byte == 8'h2C)) begin
          div_go    = 1'b1;
          phase_nxt = PH_NUM2;
          int_nxt   = '0;
          frac_nxt  = '0;
          fpos_nxt  = '0;
        end else begin
          bad_nxt = 1'b1;
        end
      end else if (in_n2) begin
        if (res == RES_END) begin
          div_go    = 1'b1;
          div_tgt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          bad_nxt = 1'b1;
        end
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      phase_r    <= PH_HASH;
      bad_r      <= 1'b0;
      sign_r     <= 2'b00;
      int_r      <= '0;
      frac_r     <= '0;
      fpos_r     <= '0;
    end else if (cmd.step) begin
      line_cnt_r <= cnt_nxt;
      phase_r    <= phase_nxt;
      bad_r      <= bad_nxt;
      sign_r     <= sign_nxt;
      int_r      <= int_nxt;
      frac_r     <= frac_nxt;
      fpos_r     <= fpos_nxt;
    end
  end

  logic [FDIG_W:0]      rem_dbl;
  logic                 qbit;
  logic [VW-1:0]        mag_v;
  logic signed [VW-1:0] val_v;

  assign rem_dbl = {rem_r, 1'b0};
  assign qbit    = (rem_dbl >= {1'b0, dvs_r});
  assign mag_v   = {1'b0, dint_r, quot_r};
  assign val_v   = dneg_r ? $signed(-mag_v) : $signed(mag_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
      bear_r <= '0;
    end else if (cmd.div_fin) begin
      if (dtgt_r) begin
        bear_r <= val_v;
      end else begin
        dist_r <= val_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && div_go) begin
      rem_r  <= frac_r;
      dvs_r  <= pow10(fpos_r);
      quot_r <= '0;
      dint_r <= int_r;
      dneg_r <= div_tgt ? sign_r[1] : sign_r[0];
      dtgt_r <= div_tgt;
      dcnt_r <= '0;
    end else if (cmd.div_run) begin
      rem_r  <= qbit ? FDIG_W'(rem_dbl - {1'b0, dvs_r}) : rem_dbl[FDIG_W-1:0];
      quot_r <= {quot_r[FRAC_BITS-2:0], qbit};
      dcnt_r <= dcnt_r + DC_W'(1);
    end
  end

  assign sts.start_div = div_go;
  assign sts.go_check  = go_chk;
  assign sts.div_last  = (dcnt_r == DC_W'(FRAC_BITS - 1));
  assign sts.line_ok   = !dist_r[VW-1] &&
                         ($unsigned(dist_r) <= (VW'(max_dist) << FRAC_BITS)) &&
                         (bear_r <= $signed(BEAR_MAX)) &&
                         (bear_r >= -$signed(BEAR_MAX));
  assign sts.rot_last  = (step_r == STEP_W'(CORDIC_STEPS - 1));

  logic [MAG_W-1:0]     mag_w;
  logic [PR_W-1:0]      prod;
  logic signed [TW-1:0] t_wrap;
  logic signed [TW-1:0] t_fold;
  logic                 fold;
  logic signed [TW-1:0] bt;
  logic signed [TW-1:0] ot;

  assign bt    = TW'(bear_r);
  assign ot    = TW'(angle_offset);
  assign mag_w = MAG_W'(p1_r >> (FRAC_BITS - 8));
  assign prod  = PR_W'(mag_w) * PR_W'(CORDIC_GAIN);

  always_comb begin
    t_wrap = theta_r;
    if (t_wrap > $signed(HALF)) begin
      t_wrap = t_wrap - $signed(HALF << 1);
    end
    if (t_wrap < -$signed(HALF)) begin
      t_wrap = t_wrap + $signed(HALF << 1);
    end
    fold   = 1'b0;
    t_fold = t_wrap;
    if (t_wrap > $signed(QUART)) begin
      t_fold = t_wrap - $signed(HALF);
      fold   = 1'b1;
    end else if (t_wrap < -$signed(QUART)) begin
      t_fold = t_wrap + $signed(HALF);
      fold   = 1'b1;
    end
  end

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] at;

  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  assign at = $signed(ZW'(atan_deg(step_r)));

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1_r    <= P1_W'(dist_r[VW-2:0]) * P1_W'(DIST_SCALE);
      theta_r <= (bt <<< (ANG_BITS - FRAC_BITS)) + (ot <<< ANG_BITS);
    end
    if (cmd.mul2) begin
      x_r    <= $signed(CW'(prod >> GAIN_W));
      y_r    <= '0;
      z_r    <= ZW'(t_fold);
      neg_r  <= fold;
      step_r <= '0;
    end else if (cmd.rot) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
      step_r <= step_r + STEP_W'(1);
    end
  end

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [CW-1:0] v,
                                                     input logic neg);
    logic signed [CW:0]   v1;
    logic signed [CW-7:0] r;
    logic signed [CW-6:0] rn;
    v1 = CW'(v) + (CW+1)'(128);
    v1 = {v[CW-1], v} + (CW+1)'(128);
    r  = (CW-6)'(v1 >>> 8);
    rn = neg ? -((CW-5)'(r)) : (CW-5)'(r);
    if (rn > (CW-5)'(262143)) begin
      return OUT_W'(262143);
    end else if (rn < -(CW-5)'(262144)) begin
      return OUT_W'(-262144);
    end
    return OUT_W'(rn);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      xo_r <= finish(x_r, neg_r);
      yo_r <= finish(y_r, neg_r);
    end
  end

  assign x_pos = xo_r;
  assign y_pos = yo_r;

endmodule

// ===== rtl/range_bearing_line_to_xy_core.sv =====
// An accepted byte leaves the input free for the next byte, except a byte that ends a number: it
// stalls the input while the fraction divider runs.
// A newline that completes a good line loads its result after the divider (skipped when the angle
// already ended), the range check, two multiplies and 20 CORDIC steps.
// Results wait in an output register; the input stalls until the result is loaded.
// Synchronous active-low reset clears the line parser and loads register defaults.
module range_bearing_line_to_xy_core
  import rbxy_pkg::*;
#(
  parameter int LINE_LIMIT = LINE_LIMIT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IN_W-1:0]         in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_x_pos,
  output logic signed [OUT_W-1:0] out_y_pos,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [OFF_W-1:0]        cfg_data
);

  logic [OFF_W-1:0]  offset_r;
  logic [MAXD_W-1:0] maxd_r;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      maxd_r   <= MAXD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ANGLE_OFFSET: offset_r <= cfg_data;
        CFG_MAX_DISTANCE: maxd_r   <= cfg_data[MAXD_W-1:0];
        default:          offset_r <= offset_r;
      endcase
    end
  end

  rbxy_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbxy_dp #(
    .LINE_LIMIT (LINE_LIMIT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .rx_byte      (in_rx_byte),
    .angle_offset ($signed(offset_r)),
    .max_dist     (maxd_r),
    .x_pos        (out_x_pos),
    .y_pos        (out_y_pos)
  );

endmodule

// ===== tb/sv/rbxy_checker.sv =====
module rbxy_checker
  import rbxy_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [IN_W-1:0]         in_rx_byte,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OUT_W-1:0] out_x_pos,
  input  logic signed [OUT_W-1:0] out_y_pos,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [OFF_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      xy_pending
);

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } xy_t;

  xy_t xy_q[$];

  logic [OFF_W-1:0]  offset_r;
  logic [MAXD_W-1:0] maxd_r;
  int unsigned       line_bytes;
  logic [3:0]        phase;
  logic              bad;
  longint            dist_q16;
  longint            bear_q16;
  int unsigned       fpos;
  logic [1:0]        signs;
  longint            int_part;
  longint            frac_part;

  longint atan_tab [CORDIC_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833};

  assign xy_pending = xy_q.size();

  function automatic void number_start();
    int_part = 0;
    frac_part = 0;
    fpos = 0;
  endfunction

  function automatic void line_start();
    line_bytes = 0;
    phase = PH_HASH;
    bad = 1'b0;
    signs = 2'b00;
    number_start();
  endfunction

  function automatic longint held_value(logic [1:0] neg_bit);
    longint p10;
    longint q;
    p10 = 1;
    for (int i = 0; i < fpos; i++) p10 = p10 * 10;
    q = (int_part <<< 16) + ((frac_part <<< 16) / p10);
    return ((signs & neg_bit) != 0) ? -q : q;
  endfunction

  function automatic void int_digit(logic [7:0] c);
    longint v;
    v = int_part * 10 + (c - 8'h30);
    int_part = (v > INT_CAP) ? INT_CAP : v;
  endfunction

  function automatic void frac_digit(logic [7:0] c);
    if (fpos < FRAC_DIGITS) begin
      frac_part = frac_part * 10 + (c - 8'h30);
      fpos++;
    end
  endfunction

  function automatic logic [1:0] number_byte(logic [3:0] base, logic [1:0] neg_bit,
                                             logic [7:0] c);
    logic [3:0] rel;
    logic       dig;
    logic       sp;
    rel = phase - base;
    dig = (c >= "0") && (c <= "9");
    sp = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    if (rel == R_WS) begin
      if (sp) return RES_TAKE;
      if (c == "+" || c == "-") begin
        if (c == "-") signs = signs | neg_bit;
        phase = base + R_SIGN;
        return RES_TAKE;
      end
    end
    if (rel == R_WS || rel == R_SIGN) begin
      if (dig) begin
        int_digit(c);
        phase = base + R_INT;
        return RES_TAKE;
      end
      if (c == ".") begin
        phase = base + R_DOT;
        return RES_TAKE;
      end
      return RES_MAL;
    end
    if (rel == R_INT) begin
      if (dig) begin
        int_digit(c);
        return RES_TAKE;
      end
      if (c == ".") begin
        phase = base + R_FRAC;
        return RES_TAKE;
      end
      return RES_END;
    end
    if (rel == R_DOT) begin
      if (dig) begin
        frac_digit(c);
        phase = base + R_FRAC;
        return RES_TAKE;
      end
      return RES_MAL;
    end
    if (rel == R_FRAC) begin
      if (dig) begin
        frac_digit(c);
        return RES_TAKE;
      end
      return RES_END;
    end
    return RES_MAL;
  endfunction

  function automatic void text_byte(logic [7:0] c);
    logic [1:0] r;
    if (bad || phase == PH_DONE) return;
    if (phase == PH_HASH) begin
      if (c == "#") begin
        phase = PH_NUM1;
        number_start();
      end else begin
        bad = 1'b1;
      end
    end else if (phase < PH_NUM2) begin
      r = number_byte(PH_NUM1, 2'b01, c);
      if (r == RES_END && c == ",") begin
        dist_q16 = held_value(2'b01);
        phase = PH_NUM2;
        number_start();
      end else if (r != RES_TAKE) begin
        bad = 1'b1;
      end
    end else if (phase < PH_DONE) begin
      r = number_byte(PH_NUM2, 2'b10, c);
      if (r == RES_END) begin
        bear_q16 = held_value(2'b10);
        phase = PH_DONE;
      end else if (r == RES_MAL) begin
        bad = 1'b1;
      end
    end else begin
      bad = 1'b1;
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] axis_out(longint v, logic neg);
    longint r;
    r = (v + 128) >>> 8;
    if (neg) r = -r;
    if (r > 262143) r = 262143;
    if (r < -262144) r = -262144;
    return r[OUT_W-1:0];
  endfunction

  function automatic xy_t polar_to_xy();
    longint half_turn;
    longint quarter;
    longint theta;
    longint mag;
    longint cx;
    longint cy;
    longint cz;
    longint nx;
    longint ny;
    logic   neg;
    xy_t    r;
    half_turn = longint'(180) <<< ANG_BITS;
    quarter = longint'(90) <<< ANG_BITS;
    neg = 1'b0;
    theta = (bear_q16 <<< 8) + (longint'($signed(offset_r)) <<< ANG_BITS);
    if (theta > half_turn) theta -= 2 * half_turn;
    if (theta < -half_turn) theta += 2 * half_turn;
    if (theta > quarter) begin
      theta -= half_turn;
      neg = 1'b1;
    end else if (theta < -quarter) begin
      theta += half_turn;
      neg = 1'b1;
    end
    mag = (dist_q16 * 16000) >>> 8;
    cx = (mag * 652032874) >>> 30;
    cy = 0;
    cz = theta;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        cz -= atan_tab[i];
      end else begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        cz += atan_tab[i];
      end
      cx = nx;
      cy = ny;
    end
    r.x = axis_out(cx, neg);
    r.y = axis_out(cy, neg);
    return r;
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    logic ok;
    if (line_bytes >= 63) begin
      line_start();
      return;
    end
    line_bytes++;
    if (c != 8'h0A) begin
      text_byte(c);
      return;
    end
    if (!bad && (phase == PH_NUM2 + R_INT || phase == PH_NUM2 + R_FRAC)) begin
      bear_q16 = held_value(2'b10);
      phase = PH_DONE;
    end
    ok = !bad && phase == PH_DONE && dist_q16 >= 0 &&
         dist_q16 <= (longint'(maxd_r) <<< 16) &&
         bear_q16 >= -(longint'(180) <<< 16) && bear_q16 <= (longint'(180) <<< 16);
    line_start();
    if (ok) xy_q.push_back(polar_to_xy());
  endfunction

  always @(posedge clk) begin
    xy_t e;
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      maxd_r <= MAXD_RST;
      dist_q16 = 0;
      bear_q16 = 0;
      line_start();
      xy_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ANGLE_OFFSET) offset_r <= cfg_data;
        else maxd_r <= cfg_data[MAXD_W-1:0];
      end
      if (in_valid && !in_stall) predict_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (xy_q.size() == 0) begin
          $error("unexpected result transfer x=%0d y=%0d", out_x_pos, out_y_pos);
          fail_count <= fail_count + 1;
        end else begin
          e = xy_q.pop_front();
          if (out_x_pos !== e.x || out_y_pos !== e.y) begin
            if (out_x_pos !== e.x)
              $error("x_pos expected %0d actual %0d", e.x, out_x_pos);
            if (out_y_pos !== e.y)
              $error("y_pos expected %0d actual %0d", e.y, out_y_pos);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import rbxy_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [IN_W-1:0]         in_rx_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_x_pos;
  logic signed [OUT_W-1:0] out_y_pos;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index;
  logic [OFF_W-1:0]        cfg_data;
  int                      fail_count;
  int                      xy_pending;
  int                      bytes_sent;
  int                      burst_left;
  int                      idle_cycles;
  int                      stall_mode;
  logic [7:0]              line_q[$];

  range_bearing_line_to_xy_core u_top (.*);

  rbxy_checker u_chk (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) :
                   $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [OFF_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (xy_pending == 0);
    repeat (64) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_number(int ip, bit neg, bit big);
    string s;
    int nf;
    if ($urandom_range(0, 3) == 0) line_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
    if (neg) line_q.push_back("-");
    else if ($urandom_range(0, 5) == 0) line_q.push_back("+");
    s = big ? $sformatf("%0d", $urandom_range(100, 99999)) : $sformatf("%0d", ip);
    if ($urandom_range(0, 7) != 0 || ip != 0)
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    if ($urandom_range(0, 1) == 0) begin
      line_q.push_back(".");
      nf = $urandom_range(0, 12);
      if (line_q[line_q.size() - 2] == "." || line_q[line_q.size() - 2] == "-" ||
          line_q[line_q.size() - 2] == "+") nf = nf + 1;
      repeat (nf) line_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end else if (line_q.size() == 0 || line_q[line_q.size() - 1] < "0" ||
                 line_q[line_q.size() - 1] > "9") begin
      line_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end
  endtask

  task automatic random_line();
    int kind;
    int pos;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(8'h0A);
    end else begin
      line_q.push_back("#");
      push_number($urandom_range(0, 16), $urandom_range(0, 19) == 0,
                  $urandom_range(0, 29) == 0);
      line_q.push_back(",");
      push_number($urandom_range(0, 181), $urandom_range(0, 1),
                  $urandom_range(0, 29) == 0);
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(32, 126)));
      if (kind >= 90) repeat ($urandom_range(40, 70)) line_q.push_back("7");
      line_q.push_back(8'h0A);
      if (kind >= 78 && kind < 90) begin
        pos = $urandom_range(0, line_q.size() - 2);
        line_q[pos] = 8'($urandom_range(0, 255));
      end
    end
    send_line();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ANGLE_OFFSET;
    cfg_data <= '0;
    bytes_sent = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("#1,0\n#10,-180\n#0,180\n#-0.00001,7\n#.5,-.25\n");
    send_text("#3.,12.999999999999\n# \t2, \r-45abc\n#11,0\n#2,180.00001\n");
    send_text("#2,\n#,5\nx#1,1\n#1 ,1\n#1,1");
    line_q.push_back(8'h00);
    line_q.push_back(8'h0A);
    line_q.push_back(8'hFF);
    line_q.push_back(8'h0A);
    send_line();
    send_text("#99999,1e5\n#1,99999\n#4.123456789012,+33.3\n");
    repeat (70) line_q.push_back("9");
    send_text("\n#5,90\n");

    write_reg(CFG_ANGLE_OFFSET, -9'sd180);
    write_reg(CFG_MAX_DISTANCE, 9'd15);
    send_text("#15,180\n#15,-90\n#15,0\n");
    write_reg(CFG_ANGLE_OFFSET, 9'd180);
    write_reg(CFG_MAX_DISTANCE, 9'd0);
    send_text("#0,-180\n#0.5,10\n#-0.0,0\n");

    for (int phase_no = 0; bytes_sent < 1700; phase_no++) begin
      write_reg(CFG_ANGLE_OFFSET, (phase_no % 3 == 0) ? 9'h100 | 9'd76 :
                OFF_W'($urandom_range(0, 360) - 180));
      write_reg(CFG_MAX_DISTANCE,
                (phase_no % 4 == 1) ? 9'd0 : OFF_W'($urandom_range(0, 15)));
      for (int k = 0; k < 20; k++) begin
        random_line();
        if (k == 10 && phase_no == 2) begin
          in_valid <= 1'b0;
          wait (xy_pending == 0);
        end
      end
    end

    in_valid <= 1'b0;
    wait (xy_pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && xy_pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rbxy_pkg.sv
rtl/rbxy_ctrl.sv
rtl/rbxy_dp.sv
rtl/range_bearing_line_to_xy_core.sv
tb/sv/rbxy_checker.sv
tb/sv/tb.sv
